/* hw/rtl/gregorian_date_add_days_core_macros.svh */
// Assertion macros for the date-add checker.
// Expects signals named clk and rst in the scope of use.
`ifndef GREGORIAN_DATE_ADD_DAYS_CORE_MACROS_SVH
`define GREGORIAN_DATE_ADD_DAYS_CORE_MACROS_SVH

// Same-cycle implication, masked during reset.
`define GDADD_ASSERT_IMP(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("gdadd: same-cycle property violated");

// Next-cycle implication, masked during reset.
`define GDADD_ASSERT_NXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("gdadd: next-cycle property violated");

`endif

/* hw/rtl/gdadd_pkg.sv */
// Types, constants and microcode for the Gregorian date-add core.
// No dependencies; imported by the core and its checker.
package gdadd_pkg;

  typedef struct packed {
    logic [4:0]  start_day;
    logic [3:0]  start_month;
    logic [13:0] start_year;
    logic [15:0] days_to_add;
  } date_req_t;

  typedef struct packed {
    logic [4:0]  new_day;
    logic [3:0]  new_month;
    logic [13:0] new_year;
    logic        date_valid;
  } date_rsp_t;

  localparam logic [13:0] YEAR_MAX    = 14'd9999;
  localparam logic [3:0]  MONTH_JAN   = 4'd1;
  localparam logic [3:0]  MONTH_FEB   = 4'd2;
  localparam logic [3:0]  MONTH_DEC   = 4'd12;
  // floor(y / 100) == (y * 5243) >> 19 for every 14-bit y
  localparam logic [26:0] RECIP100    = 27'd5243;
  localparam logic [14:0] HUNDRED     = 15'd100;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_LEAP, ST_CHECK, ST_ADV, ST_MONTH, ST_DONE, ST_SPARE
  } step_t;

  typedef enum logic [2:0] {
    OP_LOAD, OP_DIV, OP_LEAP, OP_CHECK, OP_FINAL, OP_ROLL, OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_ALWAYS, C_NO_REQ, C_INVALID, C_FINISH, C_YEAR_END, C_OUT_BUSY
  } cond_t;

  // Jump to tgt when cond holds, else go to nxt.
  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t tgt;
    step_t nxt;
  } uword_t;

  localparam uword_t UCODE [0:7] = '{
    '{op: OP_LOAD,  cond: C_NO_REQ,   tgt: ST_IDLE,  nxt: ST_DIV},
    '{op: OP_DIV,   cond: C_ALWAYS,   tgt: ST_LEAP,  nxt: ST_LEAP},
    '{op: OP_LEAP,  cond: C_ALWAYS,   tgt: ST_CHECK, nxt: ST_CHECK},
    '{op: OP_CHECK, cond: C_INVALID,  tgt: ST_DONE,  nxt: ST_ADV},
    '{op: OP_FINAL, cond: C_FINISH,   tgt: ST_DONE,  nxt: ST_MONTH},
    '{op: OP_ROLL,  cond: C_YEAR_END, tgt: ST_DIV,   nxt: ST_ADV},
    '{op: OP_EMIT,  cond: C_OUT_BUSY, tgt: ST_DONE,  nxt: ST_IDLE},
    '{op: OP_EMIT,  cond: C_ALWAYS,   tgt: ST_IDLE,  nxt: ST_IDLE}
  };

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    unique case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

/* hw/rtl/gregorian_date_add_days_core.sv */
// Gregorian date-add core: microcoded sequencer over a small date datapath.
// Depends on gdadd_pkg.
//
// Request channel (req_valid/req_stall/req): start date and day count. A
// transaction is taken only while the sequencer sits in its idle step.
// Response channel (rsp_valid/rsp_stall/rsp): new date and date_valid flag,
// one response per request, in order.
// The sequencer loads the request, derives the century quotient and the
// leap flag, checks the start date, then walks the count month by month,
// rerunning the quotient, leap and check steps after each year boundary;
// an invalid date skips the walk. One request is in work at a time.
// The response sits in an output register, so a new request is accepted
// while the previous response is still stalled; a finished date then waits
// in the done step until the output register frees up.
// Reset (rst, synchronous) returns the sequencer to idle and drops rsp_valid.
module gregorian_date_add_days_core
  import gdadd_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  date_req_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output date_rsp_t rsp
);

  step_t                  pc, pc_next;
  uword_t                 uw;
  logic [4:0]             day;
  logic [3:0]             month;
  logic [13:0]            year;
  logic [COUNT_WIDTH-1:0] remaining;
  logic [7:0]             quot;
  logic                   leap;
  logic                   valid;

  logic [4:0]  len;
  logic [4:0]  left;
  logic        finish;
  logic        date_ok;
  logic        out_busy;
  logic        cond_true;
  logic        emit;
  logic [26:0] prod;
  logic [14:0] hund;
  logic [13:0] rem100;
  logic        leap_calc;

  assign uw       = UCODE[pc];
  assign len      = month_len(month, leap);
  assign left     = len - day;
  assign finish   = remaining <= COUNT_WIDTH'(left);
  assign date_ok  = (year <= YEAR_MAX) && (len != 5'd0) && (day != 5'd0) && (day <= len);
  assign out_busy = rsp_valid && rsp_stall;

  assign prod      = 27'(year) * RECIP100;
  assign hund      = 15'(quot) * HUNDRED;
  assign rem100    = year - hund[13:0];
  assign leap_calc = (year[1:0] == 2'd0) && ((rem100 != 14'd0) || (quot[1:0] == 2'd0));

  always_comb begin
    unique case (uw.cond)
      C_ALWAYS:   cond_true = 1'b1;
      C_NO_REQ:   cond_true = !req_valid;
      C_INVALID:  cond_true = !date_ok;
      C_FINISH:   cond_true = finish;
      C_YEAR_END: cond_true = (month == MONTH_DEC);
      C_OUT_BUSY: cond_true = out_busy;
      default:    cond_true = 1'b1;
    endcase
    pc_next = cond_true ? uw.tgt : uw.nxt;
  end

  always_comb begin
    req_stall = (uw.op != OP_LOAD);
    emit      = (uw.op == OP_EMIT) && !out_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (uw.op)
      OP_LOAD: begin
        if (req_valid) begin
          day       <= req.start_day;
          month     <= req.start_month;
          year      <= req.start_year;
          remaining <= COUNT_WIDTH'(req.days_to_add);
        end
      end
      OP_DIV:   quot  <= prod[26:19];
      OP_LEAP:  leap  <= leap_calc;
      OP_CHECK: valid <= date_ok;
      OP_FINAL: begin
        if (finish) begin
          day <= day + remaining[4:0];
        end
      end
      OP_ROLL: begin
        remaining <= remaining - (COUNT_WIDTH'(left) + COUNT_WIDTH'(1));
        day       <= 5'd1;
        if (month == MONTH_DEC) begin
          month <= MONTH_JAN;
          year  <= (year >= YEAR_MAX) ? 14'd0 : year + 14'd1;
        end else begin
          month <= month + 4'd1;
        end
      end
      OP_EMIT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp.new_day    <= day;
      rsp.new_month  <= month;
      rsp.new_year   <= year;
      rsp.date_valid <= valid;
    end
  end

endmodule

/* hw/rtl/gdadd_checker.sv */
// Port-level checker for the date-add core, bound into the core module.
// Depends on gdadd_pkg and gregorian_date_add_days_core_macros.svh.
`include "gregorian_date_add_days_core_macros.svh"

module gdadd_checker
  import gdadd_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_stall,
  input date_req_t req,
  input logic      rsp_valid,
  input logic      rsp_stall,
  input date_rsp_t rsp
);

  logic req_take;
  logic rsp_good;
  logic rsp_in_range;

  assign req_take     = req_valid && !req_stall;
  assign rsp_good     = rsp_valid && rsp.date_valid;
  assign rsp_in_range = (rsp.new_day != 5'd0) && (rsp.new_month != 4'd0) &&
                        (rsp.new_month <= MONTH_DEC) && (rsp.new_year <= YEAR_MAX);

  `GDADD_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
  `GDADD_ASSERT_NXT(a_busy_after_take, req_take, req_stall)
  `GDADD_ASSERT_IMP(a_date_range, rsp_good, rsp_in_range)
  `GDADD_ASSERT_IMP(a_feb_len, rsp_good && (rsp.new_month == MONTH_FEB), rsp.new_day <= 5'd29)

endmodule

bind gregorian_date_add_days_core gdadd_checker u_gdadd_checker (.*);
